// ===== hw/rtl/hsvpc_pkg.sv =====
// Shared types, constants and helpers for the HSV pixel color converter.
// No dependencies; every other file of the block refers to it by scoped names.
package hsvpc_pkg;

	// Largest LED count the strip addressing honors; larger counts saturate here.
	localparam int STRIP_MAX = 1024;
	localparam int LIMIT_W   = 17;

	// Configuration register indexes.
	localparam logic [0:0] REG_STRIP_READY = 1'd0;
	localparam logic [0:0] REG_STRIP_LEN   = 1'd1;
	localparam logic [10:0] STRIP_LEN_RST  = 11'd8;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_READY = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;

	// Hue sectors of sixty degrees each.
	localparam logic [2:0] SEC_RED_YEL  = 3'd0;
	localparam logic [2:0] SEC_YEL_GRN  = 3'd1;
	localparam logic [2:0] SEC_GRN_CYAN = 3'd2;
	localparam logic [2:0] SEC_CYAN_BLU = 3'd3;
	localparam logic [2:0] SEC_BLU_MAG  = 3'd4;

	localparam logic [5:0] SECTOR_DEG = 6'd60;
	localparam logic [7:0] FULL_LEVEL = 8'd255;

	// Reciprocals for constant division; each was checked to be exact over
	// the full range of the dividend it is applied to.
	localparam logic [16:0] RECIP_60_SH21  = 17'd34953; // x/60, x < 2^16
	localparam logic [11:0] RECIP_6_SH14   = 12'd2731;  // x/6,  x < 1093
	localparam logic [14:0] RECIP_60_SH20  = 15'd17477; // x/60, x < 15301
	localparam logic [15:0] RECIP_255_SH23 = 16'd32897; // x/255, x < 65026

	// Fields that ride along the pipeline beside the color math.
	typedef struct packed {
		logic [9:0] idx;
		logic [1:0] status;
		logic [7:0] sat;
		logic [7:0] val;
	} pix_meta_t;

	// Truncating division of a product of two bytes by 255.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [31:0] prod;
		begin
			prod = 32'(x) * 32'(RECIP_255_SH23);
			return prod[30:23];
		end
	endfunction

endpackage

// ===== hw/rtl/hsvpc_sector.sv =====
// Hue reduction stages: splits the hue into its sector (modulo six) and the
// remainder within the sector. Depends on hsvpc_pkg.
module hsvpc_sector (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  hsvpc_pkg::pix_meta_t in_meta,
	input  logic [15:0]          in_hue,
	output logic                 out_valid,
	output hsvpc_pkg::pix_meta_t out_meta,
	output logic [2:0]           out_sector,
	output logic [5:0]           out_rem
);

	logic [32:0]          quo_prod;
	logic                 valid_s1;
	hsvpc_pkg::pix_meta_t meta_s1;
	logic [15:0]          hue_s1;
	logic [10:0]          quo_s1;

	logic [22:0] six_prod;
	logic [8:0]  quo6;
	logic [10:0] six_mult;
	logic [16:0] sixty_mult;

	logic                 valid_s2;
	hsvpc_pkg::pix_meta_t meta_s2;
	logic [2:0]           sector_s2;
	logic [5:0]           rem_s2;

	// Stage 1: hue / 60.
	assign quo_prod = 33'(in_hue) * 33'(hsvpc_pkg::RECIP_60_SH21);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= in_meta;
			hue_s1  <= in_hue;
			quo_s1  <= quo_prod[31:21];
		end
	end

	// Stage 2: remainder within the sector and the quotient folded modulo six.
	assign six_prod   = 23'(quo_s1) * 23'(hsvpc_pkg::RECIP_6_SH14);
	assign quo6       = six_prod[22:14];
	assign six_mult   = 11'({quo6, 2'b00}) + 11'({quo6, 1'b0});
	assign sixty_mult = {quo_s1, 6'b0} - 17'({quo_s1, 2'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s2   <= meta_s1;
			sector_s2 <= 3'(quo_s1 - six_mult);
			rem_s2    <= 6'(hue_s1 - sixty_mult[15:0]);
		end
	end

	assign out_valid  = valid_s2;
	assign out_meta   = meta_s2;
	assign out_sector = sector_s2;
	assign out_rem    = rem_s2;

endmodule

// ===== hw/rtl/hsvpc_terms.sv =====
// Term stages: forms p and the scaled products behind q and t.
// Depends on hsvpc_pkg for constants, the side-band struct and div255.
module hsvpc_terms (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  hsvpc_pkg::pix_meta_t in_meta,
	input  logic [2:0]           in_sector,
	input  logic [5:0]           in_rem,
	output logic                 out_valid,
	output hsvpc_pkg::pix_meta_t out_meta,
	output logic [2:0]           out_sector,
	output logic [7:0]           out_p,
	output logic [15:0]          out_mq,
	output logic [15:0]          out_mt
);

	logic                 valid_s3;
	hsvpc_pkg::pix_meta_t meta_s3;
	logic [2:0]           sector_s3;
	logic [13:0]          prod_q_s3;
	logic [13:0]          prod_t_s3;
	logic [15:0]          prod_p_s3;

	logic [28:0]          kq_prod;
	logic [28:0]          kt_prod;
	logic                 valid_s4;
	hsvpc_pkg::pix_meta_t meta_s4;
	logic [2:0]           sector_s4;
	logic [7:0]           kq_s4;
	logic [7:0]           kt_s4;
	logic [7:0]           p_s4;

	logic                 valid_s5;
	hsvpc_pkg::pix_meta_t meta_s5;
	logic [2:0]           sector_s5;
	logic [7:0]           p_s5;
	logic [15:0]          mq_s5;
	logic [15:0]          mt_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Stage 3: sat * rem, sat * (60 - rem) and val * (255 - sat).
	always_ff @(posedge clk) begin
		if (en) begin
			meta_s3   <= in_meta;
			sector_s3 <= in_sector;
			prod_q_s3 <= 14'(in_meta.sat) * 14'(in_rem);
			prod_t_s3 <= 14'(in_meta.sat) * 14'(hsvpc_pkg::SECTOR_DEG - in_rem);
			prod_p_s3 <= 16'(in_meta.val) * 16'(hsvpc_pkg::FULL_LEVEL - in_meta.sat);
		end
	end

	// Stage 4: divide the fractional products by 60 and p's product by 255.
	assign kq_prod = 29'(prod_q_s3) * 29'(hsvpc_pkg::RECIP_60_SH20);
	assign kt_prod = 29'(prod_t_s3) * 29'(hsvpc_pkg::RECIP_60_SH20);

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s4   <= meta_s3;
			sector_s4 <= sector_s3;
			kq_s4     <= kq_prod[27:20];
			kt_s4     <= kt_prod[27:20];
			p_s4      <= hsvpc_pkg::div255(prod_p_s3);
		end
	end

	// Stage 5: val * (255 - k) for q and t.
	always_ff @(posedge clk) begin
		if (en) begin
			meta_s5   <= meta_s4;
			sector_s5 <= sector_s4;
			p_s5      <= p_s4;
			mq_s5     <= 16'(meta_s4.val) * 16'(hsvpc_pkg::FULL_LEVEL - kq_s4);
			mt_s5     <= 16'(meta_s4.val) * 16'(hsvpc_pkg::FULL_LEVEL - kt_s4);
		end
	end

	assign out_valid  = valid_s5;
	assign out_meta   = meta_s5;
	assign out_sector = sector_s5;
	assign out_p      = p_s5;
	assign out_mq     = mq_s5;
	assign out_mt     = mt_s5;

endmodule

// ===== hw/rtl/hsvpc_mix.sv =====
// Output stage: finishes q and t, routes the channels by sector, blanks
// rejected pixels and holds the result register. Depends on hsvpc_pkg.
module hsvpc_mix (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  hsvpc_pkg::pix_meta_t in_meta,
	input  logic [2:0]           in_sector,
	input  logic [7:0]           in_p,
	input  logic [15:0]          in_mq,
	input  logic [15:0]          in_mt,
	output logic                 out_valid,
	output logic [9:0]           out_index,
	output logic [7:0]           out_red,
	output logic [7:0]           out_green,
	output logic [7:0]           out_blue,
	output logic [1:0]           out_status
);

	logic [7:0] q;
	logic [7:0] t;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	logic       valid_s6;
	logic [9:0] index_s6;
	logic [7:0] red_s6;
	logic [7:0] green_s6;
	logic [7:0] blue_s6;
	logic [1:0] status_s6;

	assign q = hsvpc_pkg::div255(in_mq);
	assign t = hsvpc_pkg::div255(in_mt);

	always_comb begin
		unique case (in_sector)
			hsvpc_pkg::SEC_RED_YEL: begin
				red = in_meta.val; green = t; blue = in_p;
			end
			hsvpc_pkg::SEC_YEL_GRN: begin
				red = q; green = in_meta.val; blue = in_p;
			end
			hsvpc_pkg::SEC_GRN_CYAN: begin
				red = in_p; green = in_meta.val; blue = t;
			end
			hsvpc_pkg::SEC_CYAN_BLU: begin
				red = in_p; green = q; blue = in_meta.val;
			end
			hsvpc_pkg::SEC_BLU_MAG: begin
				red = t; green = in_p; blue = in_meta.val;
			end
			default: begin
				red = in_meta.val; green = in_p; blue = q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= in_valid;
		end
	end

	// A rejected pixel keeps its index but drives all channels dark.
	always_ff @(posedge clk) begin
		if (en) begin
			index_s6  <= in_meta.idx;
			status_s6 <= in_meta.status;
			if (in_meta.status == hsvpc_pkg::ST_OK) begin
				red_s6   <= red;
				green_s6 <= green;
				blue_s6  <= blue;
			end else begin
				red_s6   <= '0;
				green_s6 <= '0;
				blue_s6  <= '0;
			end
		end
	end

	assign out_valid  = valid_s6;
	assign out_index  = index_s6;
	assign out_red    = red_s6;
	assign out_green  = green_s6;
	assign out_blue   = blue_s6;
	assign out_status = status_s6;

endmodule

// ===== hw/rtl/hsv_pixel_color_converter.sv =====
// Top level of the HSV pixel color converter: configuration registers,
// pixel checks and the six-stage color pipeline. Depends on hsvpc_pkg,
// hsvpc_sector, hsvpc_terms and hsvpc_mix.
//
// Usage: pixels enter on the s_ stream, one beat per pixel, carrying the
// index, hue in degrees, saturation and value. Each input beat yields
// exactly one output beat on the m_ stream with the index, the red, blue
// and green levels in strip wire order, and a status code. A pixel is
// rejected with status "not ready" while strip_ready is clear, otherwise
// with "out of range" when its index is at or above the LED count (the
// count saturates at 1024). Rejected pixels leave all channels at zero.
// Throughput is one pixel per clock while the receiver takes each result.
// The pixel passes six registers. The stages are hue / 60, the sector
// fold, the term products, the divides by 60 and 255, the value scaling,
// and the final divide with channel routing, each behind its own register.
// The stages advance together: when the output register holds a beat that
// the receiver does not take, s_tready drops and the whole pipeline holds,
// so no beat is dropped or repeated. Bubbles in the input are carried as
// cleared valid bits. Reset clears all valid bits, strip_ready to zero and
// the LED count to eight. Configuration is written through cfg_we,
// cfg_index and cfg_data, and should only change while no pixel is in flight.
module hsv_pixel_color_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [9:0] pixel_index, [25:10] hue_degrees, [33:26] saturation,
	// [41:34] brightness, [47:42] zero
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [9:0] out_index, [17:10] wire_first, [25:18] wire_second,
	// [33:26] wire_third, [35:34] status, [39:36] zero
	output logic [39:0] m_tdata
);

	logic        strip_ready_q;
	logic [10:0] strip_len_q;

	logic                          en;
	logic [hsvpc_pkg::LIMIT_W-1:0] count_wide;
	logic [hsvpc_pkg::LIMIT_W-1:0] limit;
	hsvpc_pkg::pix_meta_t          in_meta;

	logic                 sec_valid;
	hsvpc_pkg::pix_meta_t sec_meta;
	logic [2:0]           sec_sector;
	logic [5:0]           sec_rem;

	logic                 trm_valid;
	hsvpc_pkg::pix_meta_t trm_meta;
	logic [2:0]           trm_sector;
	logic [7:0]           trm_p;
	logic [15:0]          trm_mq;
	logic [15:0]          trm_mt;

	logic [9:0] res_index;
	logic [7:0] res_red;
	logic [7:0] res_green;
	logic [7:0] res_blue;
	logic [1:0] res_status;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_ready_q <= 1'b0;
			strip_len_q   <= hsvpc_pkg::STRIP_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hsvpc_pkg::REG_STRIP_READY: strip_ready_q <= cfg_data[0];
				hsvpc_pkg::REG_STRIP_LEN:   strip_len_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline moves whenever the output register is empty or being read.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Entry sets status; user keeps configuration steady while busy, unchecked.
	assign count_wide = hsvpc_pkg::LIMIT_W'(strip_len_q);
	assign limit      = (count_wide > hsvpc_pkg::LIMIT_W'(hsvpc_pkg::STRIP_MAX)) ?
		hsvpc_pkg::LIMIT_W'(hsvpc_pkg::STRIP_MAX) : count_wide;

	always_comb begin
		in_meta.idx = s_tdata[9:0];
		in_meta.sat = s_tdata[33:26];
		in_meta.val = s_tdata[41:34];
		if (!strip_ready_q) begin
			in_meta.status = hsvpc_pkg::ST_NOT_READY;
		end else if (hsvpc_pkg::LIMIT_W'(s_tdata[9:0]) >= limit) begin
			in_meta.status = hsvpc_pkg::ST_RANGE;
		end else begin
			in_meta.status = hsvpc_pkg::ST_OK;
		end
	end

	hsvpc_sector u_sector (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_tvalid),
		.in_meta    (in_meta),
		.in_hue     (s_tdata[25:10]),
		.out_valid  (sec_valid),
		.out_meta   (sec_meta),
		.out_sector (sec_sector),
		.out_rem    (sec_rem)
	);

	hsvpc_terms u_terms (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (sec_valid),
		.in_meta    (sec_meta),
		.in_sector  (sec_sector),
		.in_rem     (sec_rem),
		.out_valid  (trm_valid),
		.out_meta   (trm_meta),
		.out_sector (trm_sector),
		.out_p      (trm_p),
		.out_mq     (trm_mq),
		.out_mt     (trm_mt)
	);

	hsvpc_mix u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (trm_valid),
		.in_meta    (trm_meta),
		.in_sector  (trm_sector),
		.in_p       (trm_p),
		.in_mq      (trm_mq),
		.in_mt      (trm_mt),
		.out_valid  (m_tvalid),
		.out_index  (res_index),
		.out_red    (res_red),
		.out_green  (res_green),
		.out_blue   (res_blue),
		.out_status (res_status)
	);

	// Wire order on the strip is red, blue, green.
	assign m_tdata = {4'b0, res_status, res_green, res_blue, res_red, res_index};

	// A rejected pixel never lights any channel.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res_status != hsvpc_pkg::ST_OK) |->
		(res_red == '0) && (res_green == '0) && (res_blue == '0))
		else $error("rejected pixel carries nonzero channel levels");

	// Only the three defined status codes ever leave the block.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_status == hsvpc_pkg::ST_OK) ||
		(res_status == hsvpc_pkg::ST_NOT_READY) || (res_status == hsvpc_pkg::ST_RANGE))
		else $error("undefined status code on output");

	// While the receiver stalls a full output register, no new pixel may enter.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted while output stalled");

	// A held result stays unchanged through the following edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

// ===== dv/tb_hsv_pixel_color_converter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for hsv_pixel_color_converter: pixels stream in with random gaps,
// and every result beat is compared with a behavioral HSV-to-strip color predictor.
// Depends on hsvpc_pkg and the converter RTL only.
module tb_hsv_pixel_color_converter;

	// This limit sits far above the length of a normal run, so it leaves a wide margin.
	localparam int RUN_LIMIT  = 400000;
	// The pipeline is six stages deep, and this wait is enough for it to go quiet.
	localparam int DRAIN_WAIT = 12;
	// This is the chance, in percent, that a side idles in a given cycle.
	localparam int IDLE_PCT   = 31;

	// One expected beat on the strip side, with its fields in wire order.
	typedef struct {
		logic [9:0] idx;
		logic [7:0] red;
		logic [7:0] blue;
		logic [7:0] green;
		logic [1:0] status;
	} strip_beat_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [10:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	// [9:0] pixel_index, [25:10] hue_degrees, [33:26] saturation,
	// [41:34] brightness, [47:42] zero
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// [9:0] out_index, [17:10] wire_first (red), [25:18] wire_second (blue),
	// [33:26] wire_third (green), [35:34] status, [39:36] zero
	logic [39:0] m_tdata;

	// The testbench keeps its own copy of the two configuration registers.
	logic        model_ready;
	logic [10:0] model_leds;

	// These hold the color beats still owed by the block, oldest first.
	strip_beat_t color_queue[$];
	strip_beat_t oldest_beat;

	int  err_count   = 0;
	int  cycle_count = 0;
	// These switch random idling on for the sending side and the receiving side.
	bit  tx_gaps;
	bit  rx_gaps;

	hsv_pixel_color_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// This computes one of the q or t terms: the value dimmed by a saturation share of
	// frac/60. Both divisions truncate.
	function automatic int unsigned fade_level(input int unsigned level, input int unsigned sat,
			input int unsigned frac);
		int unsigned cut;
		cut = (sat * frac) / 60;
		return (level * (255 - cut)) / 255;
	endfunction

	// This predicts the strip beat for one pixel from the current register copy.
	function automatic strip_beat_t hsv_to_strip(input logic [9:0] idx, input logic [15:0] hue,
			input logic [7:0] sat, input logic [7:0] val);
		strip_beat_t beat;
		int unsigned h, s, v, arc, rem, p, q, t, r, g, b, limit;
		h = hue;
		s = sat;
		v = val;
		// Hue wraps modulo 360 because the sector is taken modulo six.
		arc = (h / 60) % 6;
		rem = h % 60;
		p = (v * (255 - s)) / 255;
		q = fade_level(v, s, rem);
		t = fade_level(v, s, 60 - rem);
		case (3'(arc))
			hsvpc_pkg::SEC_RED_YEL: begin
				r = v; g = t; b = p;
			end
			hsvpc_pkg::SEC_YEL_GRN: begin
				r = q; g = v; b = p;
			end
			hsvpc_pkg::SEC_GRN_CYAN: begin
				r = p; g = v; b = t;
			end
			hsvpc_pkg::SEC_CYAN_BLU: begin
				r = p; g = q; b = v;
			end
			hsvpc_pkg::SEC_BLU_MAG: begin
				r = t; g = p; b = v;
			end
			default: begin
				r = v; g = p; b = q;
			end
		endcase
		// A count above the addressable maximum saturates there.
		limit = (model_leds > hsvpc_pkg::STRIP_MAX) ? hsvpc_pkg::STRIP_MAX : model_leds;
		beat.idx = idx;
		// The ready check comes before the range check.
		if (!model_ready) begin
			beat.status = hsvpc_pkg::ST_NOT_READY;
		end else if (idx >= limit) begin
			beat.status = hsvpc_pkg::ST_RANGE;
		end else begin
			beat.status = hsvpc_pkg::ST_OK;
		end
		// Rejected pixels carry black on all three channels.
		if (beat.status != hsvpc_pkg::ST_OK) begin
			r = 0; g = 0; b = 0;
		end
		beat.red   = r[7:0];
		beat.blue  = b[7:0];
		beat.green = g[7:0];
		return beat;
	endfunction

	task automatic report_mismatch(input string what, input logic [39:0] got,
			input logic [39:0] want);
		$display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
		err_count++;
	endtask

	// This drives one pixel beat and records its prediction once the beat is accepted.
	// When the task returns, the clock edge that accepted the beat has just passed.
	task automatic send_pixel(input logic [9:0] idx, input logic [15:0] hue,
			input logic [7:0] sat, input logic [7:0] val);
		while (tx_gaps && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, val, sat, hue, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		color_queue.push_back(hsv_to_strip(idx, hue, sat, val));
	endtask

	// This stops sending and waits until every owed beat has arrived and the pipeline is quiet.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (color_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// This writes both registers back to back. Only bit zero of the ready word is meant
	// to count; the upper bits are there to exercise the masking in the block.
	task automatic write_config(input logic [10:0] ready_word, input logic [10:0] count);
		cfg_we    <= 1'b1;
		cfg_index <= hsvpc_pkg::REG_STRIP_READY;
		cfg_data  <= ready_word;
		@(posedge clk);
		model_ready = ready_word[0];
		cfg_index <= hsvpc_pkg::REG_STRIP_LEN;
		cfg_data  <= count;
		@(posedge clk);
		model_leds = count;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Indexes are drawn around the current limit so that both accepted and rejected
	// pixels show up often.
	function automatic logic [9:0] pick_index();
		int unsigned lim, hi;
		lim = (model_leds > hsvpc_pkg::STRIP_MAX) ? hsvpc_pkg::STRIP_MAX : model_leds;
		hi  = (lim + 1 > 1023) ? 1023 : lim + 1;
		case ($urandom_range(3))
			0: return 10'($urandom);
			1: return 10'($urandom_range(hi, (lim > 0) ? lim - 1 : 0));
			2: return (lim == 0) ? 10'd0 : 10'($urandom_range(lim - 1));
			default: return $urandom_range(1) ? 10'd1023 : 10'd0;
		endcase
	endfunction

	// Hues cover the full 16-bit range, one plain turn, sector edges, and the top end.
	function automatic logic [15:0] pick_hue();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(359));
			2: return 16'(60 * $urandom_range(1092) + ($urandom_range(1) ? 59 : 0));
			default: return 16'(65535 - $urandom_range(400));
		endcase
	endfunction

	function automatic logic [7:0] pick_level();
		if ($urandom_range(7) == 0) begin
			return $urandom_range(1) ? 8'd255 : 8'd0;
		end
		return 8'($urandom);
	endfunction

	// Right after reset the strip is not ready, so every pixel must come back rejected.
	task automatic test_reset_state();
		send_pixel(10'd0, 16'd0, 8'd255, 8'd255);
		send_pixel(10'd7, 16'd120, 8'd255, 8'd255);
		send_pixel(10'd1023, 16'd65535, 8'd0, 8'd0);
		drain();
	endtask

	// This walks every sector edge, hue wrap past 359, and the saturation and value
	// extremes while all indexes are in range.
	task automatic test_sector_corners();
		logic [15:0] hues[14] = '{16'd0, 16'd59, 16'd60, 16'd119, 16'd120, 16'd179, 16'd180,
			16'd239, 16'd240, 16'd299, 16'd300, 16'd359, 16'd360, 16'd65535};
		write_config(11'd1, 11'd1024);
		for (int i = 0; i < 14; i++) begin
			send_pixel((i == 0) ? 10'd1023 : 10'(i), hues[i],
				(i % 4 == 3) ? 8'd0 : 8'(255 - i), (i == 6) ? 8'd0 : 8'd255);
		end
		drain();
	endtask

	// This covers the range check at its edges: an empty strip, a ready word with only upper
	// bits set, the count boundary, and counts that saturate at the maximum.
	task automatic test_index_range();
		write_config(11'd1, 11'd0);
		send_pixel(10'd0, 16'd30, 8'd128, 8'd200);
		drain();
		write_config(11'h7FE, 11'd2047);
		send_pixel(10'd1023, 16'd200, 8'd128, 8'd200);
		drain();
		write_config(11'd1, 11'd8);
		send_pixel(10'd7, 16'd90, 8'd77, 8'd180);
		send_pixel(10'd8, 16'd90, 8'd77, 8'd180);
		drain();
		write_config(11'h7FF, 11'd2047);
		send_pixel(10'd1023, 16'd330, 8'd255, 8'd1);
		drain();
	endtask

	// These are random pixels under several settings. The first phase runs with no idling
	// on either side, so the pipeline is kept full from end to end.
	task automatic test_random_pixels();
		int phase_len[6] = '{450, 400, 120, 120, 400, 400};
		for (int ph = 0; ph < 6; ph++) begin
			tx_gaps = (ph != 0);
			rx_gaps = (ph != 0);
			case (ph)
				0: write_config(11'd1, 11'd1024);
				1: write_config(11'd1, 11'($urandom_range(1023, 1)));
				2: write_config({10'($urandom), 1'b0}, 11'($urandom_range(2047)));
				3: write_config(11'd1, 11'd0);
				4: write_config(11'd1, 11'd2047);
				default: write_config({10'($urandom), 1'b1}, 11'($urandom_range(2047, 1025)));
			endcase
			for (int n = 0; n < phase_len[ph]; n++) begin
				send_pixel(pick_index(), pick_hue(), pick_level(), pick_level());
			end
			drain();
		end
	endtask

	// The receiver stalls at random, except when receiver idling is switched off.
	always @(posedge clk) begin
		m_tready <= !rx_gaps || ($urandom_range(99) >= IDLE_PCT);
	end

	// Each accepted result beat is compared field by field with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (color_queue.size() == 0) begin
				report_mismatch("beat with nothing owed", m_tdata, 40'd0);
			end else begin
				oldest_beat = color_queue.pop_front();
				if (m_tdata[9:0] !== oldest_beat.idx)
					report_mismatch("out_index", m_tdata[9:0], oldest_beat.idx);
				if (m_tdata[17:10] !== oldest_beat.red)
					report_mismatch("wire_first", m_tdata[17:10], oldest_beat.red);
				if (m_tdata[25:18] !== oldest_beat.blue)
					report_mismatch("wire_second", m_tdata[25:18], oldest_beat.blue);
				if (m_tdata[33:26] !== oldest_beat.green)
					report_mismatch("wire_third", m_tdata[33:26], oldest_beat.green);
				if (m_tdata[35:34] !== oldest_beat.status)
					report_mismatch("status", m_tdata[35:34], oldest_beat.status);
				if (m_tdata[39:36] !== 4'd0)
					report_mismatch("pad bits", m_tdata[39:36], 4'd0);
			end
		end
	end

	// This watchdog ends a run that hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("tb_hsv_pixel_color_converter: errors");
			$finish;
		end
	end

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= hsvpc_pkg::REG_STRIP_READY;
		cfg_data  <= 11'd0;
		s_tvalid  <= 1'b0;
		s_tdata   <= 48'd0;
		m_tready  <= 1'b0;
		tx_gaps     = 1'b1;
		rx_gaps     = 1'b1;
		model_ready = 1'b0;
		model_leds  = hsvpc_pkg::STRIP_LEN_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_sector_corners();
		test_index_range();
		test_random_pixels();

		if (err_count == 0) begin
			$display("tb_hsv_pixel_color_converter: clean");
		end else begin
			$display("tb_hsv_pixel_color_converter: errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/hsvpc_pkg.sv
hw/rtl/hsvpc_sector.sv
hw/rtl/hsvpc_terms.sv
hw/rtl/hsvpc_mix.sv
hw/rtl/hsv_pixel_color_converter.sv
dv/tb_hsv_pixel_color_converter.sv
